[rtl/assert_macros.svh]
// Assertion macros for the RTL files of the time-of-day clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define FTC_ASSERT_SAME(lbl, clk_sig, rst_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("ftc assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define FTC_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("ftc assertion failed");
`else
`define FTC_ASSERT_SAME(lbl, clk_sig, rst_sig, ante, cons)
`define FTC_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons)
`endif
`endif

[rtl/ftc_pkg.sv]
// Package with the constants and time record of the time-of-day clock.
`default_nettype none
package ftc_pkg;
    localparam int TICK_INCREMENT = 256;
    localparam int DAY_BITS       = 16;
    localparam int DAYS_OUT_W     = 16;
    localparam int PERIOD_W       = 32;
    localparam int ACC_W          = PERIOD_W + 1;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000);

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    // Register indexes on the configuration port.
    localparam logic REG_PERIOD_COUNTS = 1'b0;

    typedef struct packed {
        logic                half;
        logic [5:0]          sec;
        logic [5:0]          min;
        logic [4:0]          hour;
        logic [DAY_BITS-1:0] day;
    } time_t;
endpackage
`default_nettype wire

[rtl/ftc_time_advance.sv]
// Half-second carry chain through seconds, minutes, hours and days.
`default_nettype none
module ftc_time_advance
    import ftc_pkg::*;
(
    input  time_t cur_time,
    input  logic  step,
    output time_t next_time
);
    logic half_wrap;
    logic sec_wrap;
    logic min_wrap;
    logic hour_wrap;

    assign half_wrap = step && cur_time.half;
    assign sec_wrap  = half_wrap && (cur_time.sec == SEC_LAST);
    assign min_wrap  = sec_wrap && (cur_time.min == MIN_LAST);
    assign hour_wrap = min_wrap && (cur_time.hour == HOUR_LAST);

    always_comb
    begin
        next_time = cur_time;
        if (step)
        begin
            next_time.half = ~cur_time.half;
        end
        if (half_wrap)
        begin
            next_time.sec = sec_wrap ? 6'd0 : cur_time.sec + 6'd1;
        end
        if (sec_wrap)
        begin
            next_time.min = min_wrap ? 6'd0 : cur_time.min + 6'd1;
        end
        if (min_wrap)
        begin
            next_time.hour = hour_wrap ? 5'd0 : cur_time.hour + 5'd1;
        end
        if (hour_wrap)
        begin
            next_time.day = cur_time.day + DAY_BITS'(1);
        end
    end
endmodule
`default_nettype wire

[rtl/fractional_tick_time_of_day_clock_core.sv]
// Top level of the fractional-tick time-of-day clock.
//
// Usage: each input beat carries one bit, tick, that marks one overflow of
// an 8-bit timer. A tick adds 256 timer counts to a 33-bit accumulator. When
// the accumulator reaches period_counts, the period is subtracted, the
// remainder is kept, and the time advances by one half-second, carrying into
// seconds, minutes, hours and a wrapping 16-bit day counter.
// Every input beat yields exactly one output beat with the current time and
// step_event, which is high when that beat advanced the half-second count.
// An accepted beat waits in the input register; when the result register is
// free, one pass through the accumulator and carry chain loads the result
// register, where out_valid rises. The block takes one beat per cycle while
// the receiver does not stall. When the receiver stalls, the result register
// holds its beat and the input register still takes one more beat; after
// that in_ready drops until the result is taken. Reset clears the time, the
// accumulator and both valid flags, and sets period_counts to 500000. The
// period is written over the APB port at byte address 0 and should only
// change while the block is idle.
`default_nettype none
`include "assert_macros.svh"
module fractional_tick_time_of_day_clock_core
    import ftc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  tick,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  half_second,
    output logic [5:0]            seconds,
    output logic [5:0]            minutes,
    output logic [4:0]            hours,
    output logic [DAYS_OUT_W-1:0] days,
    output logic                  step_event
);
    // Configuration register.
    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_write;
    logic                cfg_index;

    // Input stage.
    logic in_valid_reg;
    logic tick_reg;

    // Clock state.
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_sum;
    logic [ACC_W-1:0] acc_next;
    time_t            time_reg;
    time_t            time_next;
    logic             step;

    // Result stage.
    logic  out_valid_reg;
    time_t res_time_reg;
    logic  res_step_reg;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    logic move;

    // High while the seconds, minutes and hours of the stored time lie inside their ranges.
    logic time_in_range;

    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (cfg_index == REG_PERIOD_COUNTS) ? period_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_write && (cfg_index == REG_PERIOD_COUNTS))
        begin
            period_reg <= pwdata;
        end
    end

    assign move     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || move;

    // Accumulator update: a tick adds the increment, and a crossing of the
    // period subtracts it once. A period of zero therefore steps every tick.
    always_comb
    begin
        acc_sum  = acc_reg + ACC_W'(TICK_INCREMENT);
        acc_next = acc_reg;
        step     = 1'b0;
        if (tick_reg)
        begin
            if (acc_sum >= {1'b0, period_reg})
            begin
                acc_next = acc_sum - {1'b0, period_reg};
                step     = 1'b1;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    ftc_time_advance u_advance (
        .cur_time  (time_reg),
        .step      (step),
        .next_time (time_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            time_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                time_reg      <= time_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tick_reg <= tick;
        end
        if (move)
        begin
            res_time_reg <= time_next;
            res_step_reg <= step;
        end
    end

    assign out_valid   = out_valid_reg;
    assign half_second = res_time_reg.half;
    assign seconds     = res_time_reg.sec;
    assign minutes     = res_time_reg.min;
    assign hours       = res_time_reg.hour;
    assign days        = res_time_reg.day[DAYS_OUT_W-1:0];
    assign step_event  = res_step_reg;

    assign time_in_range = (time_reg.sec <= SEC_LAST) && (time_reg.min <= MIN_LAST)
                           && (time_reg.hour <= HOUR_LAST);

    // The time only changes when an item steps it.
    `FTC_ASSERT_NEXT(a_time_hold, clk, rst_n, !(move && step), $stable(time_reg))
    // The stored time always stays inside its ranges.
    `FTC_ASSERT_SAME(a_time_range, clk, rst_n, 1'b1, time_in_range)
    // A beat that left the input register shows up as a valid result.
    `FTC_ASSERT_NEXT(a_move_result, clk, rst_n, move, out_valid_reg)
    // A beat stuck in the input register keeps its tick.
    `FTC_ASSERT_NEXT(a_input_hold, clk, rst_n, in_valid_reg && !move, in_valid_reg && $stable(tick_reg))
endmodule
`default_nettype wire

[sim/tb_fractional_tick_time_of_day_clock_core.sv]
// Self-checking testbench for the fractional-tick time-of-day clock core.
`default_nettype none
module tb_fractional_tick_time_of_day_clock_core;
    import ftc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct run is roughly 830 beats, each waiting out the
    // longest input gap and output stall, plus the register phases; even so
    // it stays far below CYCLE_LIMIT, so this limit is generous.
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_PHASES = 8;
    localparam int BEATS_PER_PHASE = 100;

    // One expected output beat: the time of day after the input beat, plus
    // the flag that says whether that beat moved the half-second count.
    typedef struct {
        time_t tod;
        logic  stepped;
    } clock_reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  tick = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  half_second;
    logic [5:0]            seconds;
    logic [5:0]            minutes;
    logic [4:0]            hours;
    logic [DAYS_OUT_W-1:0] days;
    logic                  step_event;

    // Private copy of the block's state, advanced once per accepted beat.
    logic [ACC_W-1:0]    acc_model = '0;
    logic [PERIOD_W-1:0] period_model = PERIOD_RESET;
    time_t               tod_model = '0;

    logic           tick_pending[$];
    clock_reading_t time_expected[$];

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    fractional_tick_time_of_day_clock_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tick        (tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .half_second (half_second),
        .seconds     (seconds),
        .minutes     (minutes),
        .hours       (hours),
        .days        (days),
        .step_event  (step_event)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // Advances the private clock state by one accepted input beat and files
    // the reading that the block must return for it. The accumulator is one
    // bit wider than the period and wraps at that width; a period of zero
    // always compares true, so every tick then steps the time.
    task automatic predict_beat(input logic tick_bit);
        clock_reading_t reading;
        reading.stepped = 1'b0;
        if (tick_bit)
        begin
            acc_model = acc_model + ACC_W'(TICK_INCREMENT);
            if (acc_model >= {1'b0, period_model})
            begin
                acc_model = acc_model - {1'b0, period_model};
                reading.stepped = 1'b1;
                // Carry chain: half-second, then seconds, minutes, hours and
                // finally the day counter, which wraps at its own width.
                if (!tod_model.half)
                    tod_model.half = 1'b1;
                else
                begin
                    tod_model.half = 1'b0;
                    if (tod_model.sec != SEC_LAST)
                        tod_model.sec = tod_model.sec + 6'd1;
                    else
                    begin
                        tod_model.sec = '0;
                        if (tod_model.min != MIN_LAST)
                            tod_model.min = tod_model.min + 6'd1;
                        else
                        begin
                            tod_model.min = '0;
                            if (tod_model.hour != HOUR_LAST)
                                tod_model.hour = tod_model.hour + 5'd1;
                            else
                            begin
                                tod_model.hour = '0;
                                tod_model.day = tod_model.day + 1'b1;
                            end
                        end
                    end
                end
            end
        end
        reading.tod = tod_model;
        time_expected.push_back(reading);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Input driver. When the current beat is taken (or none is up), the next
    // one is pulled from the pending queue, unless an idle burst is running.
    // Valid is assigned once per edge, so a back-to-back beat never sees a
    // low-then-high pair in the same time step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tick     <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_beat(tick);
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_pending.size() != 0)
                begin
                    in_valid <= 1'b1;
                    tick     <= tick_pending.pop_front();
                    // Start an idle burst after this beat now and then, so
                    // gaps land on every point of the block's pipeline.
                    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
                        gap_left <= $urandom_range(19, 1);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor. Every accepted output beat is matched against the
    // oldest expected reading; out_ready stalls in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (time_expected.size() == 0)
                begin
                    $error("output beat with no expected reading pending");
                    mismatches++;
                end
                else
                begin
                    clock_reading_t want;
                    want = time_expected.pop_front();
                    check_field("half_second", 32'(want.tod.half), 32'(half_second));
                    check_field("seconds", 32'(want.tod.sec), 32'(seconds));
                    check_field("minutes", 32'(want.tod.min), 32'(minutes));
                    check_field("hours", 32'(want.tod.hour), 32'(hours));
                    check_field("days", 32'(want.tod.day), 32'(days));
                    check_field("step_event", 32'(want.stepped), 32'(step_event));
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct)
            begin
                // Start a stall burst; stall_left holds the rest of its length.
                stall_left <= $urandom_range(18, 0);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fractional_tick_time_of_day_clock_core test failed");
            $finish;
        end
    end

    // Waits until every queued beat has gone in and every expected reading
    // has come out, then lets the input and result registers settle with margin.
    task automatic wait_idle();
        while (tick_pending.size() != 0 || in_valid || time_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes period_counts over APB (setup, then access) and reads it back.
    task automatic program_period(input logic [PERIOD_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_PERIOD_COUNTS);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        period_model = value;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_PERIOD_COUNTS);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("period_counts readback mismatch: expected %0d, actual %0d",
                   value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random period: mostly small enough that half-seconds step often, with
    // zero, values below the increment and the occasional huge one.
    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return PERIOD_W'($urandom_range(255, 1));
            2:       return PERIOD_W'(TICK_INCREMENT);
            3:       return PERIOD_W'($urandom_range(1024, 257));
            4:       return PERIOD_W'($urandom_range(4096, 1025));
            5:       return PERIOD_W'($urandom);
            default: return PERIOD_W'($urandom_range(512, 1));
        endcase
    endfunction

    initial
    begin
        int unsigned tick_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part. Reset period: ticks only build up the accumulator.
        gap_pct   = 20;
        stall_pct = 20;
        tick_pending = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        wait_idle();

        // Period of zero: the compare always passes and every tick steps.
        program_period('0);
        tick_pending = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        wait_idle();

        // Period equal to the increment: exact step on each tick.
        program_period(PERIOD_W'(TICK_INCREMENT));
        tick_pending = '{1'b1, 1'b1, 1'b0, 1'b1};
        wait_idle();

        // Period just below the increment: one subtraction per tick, so the
        // accumulator keeps growing.
        program_period(PERIOD_W'(TICK_INCREMENT - 1));
        tick_pending = '{1'b1, 1'b1, 1'b1};
        wait_idle();

        // Period just above the increment: here every tick steps.
        program_period(PERIOD_W'(TICK_INCREMENT + 1));
        tick_pending = '{1'b1, 1'b1, 1'b1};
        wait_idle();

        // Largest period: no step within any reachable number of ticks.
        program_period('1);
        tick_pending = '{1'b1, 1'b1, 1'b0};
        wait_idle();

        // Random part: one period per phase, tick density and idling varied.
        // The last phase runs with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
            begin
                program_period(PERIOD_W'(1));
                gap_pct   = 0;
                stall_pct = 0;
                tick_pct  = 90;
            end
            else
            begin
                program_period(pick_period());
                gap_pct   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(30, 5);
                stall_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(30, 5);
                tick_pct  = $urandom_range(100, 30);
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                tick_pending.push_back($urandom_range(99, 0) < tick_pct);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (time_expected.size() != 0)
        begin
            $error("%0d expected readings never arrived", time_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("fractional_tick_time_of_day_clock_core test passed");
        else
            $display("fractional_tick_time_of_day_clock_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
